>>> hw/rtl/tksi_pkg.sv
package tksi_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = 5;
  localparam int KEY_W = 32;
  localparam int ID_W = 32;
  localparam int RIDX_W = 4;
  localparam int PLACED_W = 4;
  localparam int HELD_W = 5;
  localparam int IN_DATA_W = 72;
  localparam int OUT_DATA_W = 80;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 5;

  // Common widths for comparing counts against the narrow fields.
  localparam int RD_W = (CNT_W > RIDX_W) ? CNT_W : RIDX_W;
  localparam int PL_W = (CNT_W > PLACED_W) ? CNT_W : PLACED_W;
  localparam int CW_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIES_AFTER = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_COMPARE = 2'd1,
    ST_EXECUTE = 2'd2
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic execute;
  } ctrl_cmd_t;

  function automatic logic [CAP_W-1:0] clamp_capacity(input logic [CAP_W-1:0] v);
    logic [CAP_W-1:0] c;
    c = v;
    if (c == '0) c = CAP_W'(1);
    if (int'(c) > MAX_ENTRIES) c = CAP_W'(MAX_ENTRIES);
    return c;
  endfunction

endpackage

>>> hw/rtl/tksi_ctrl.sv
module tksi_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output tksi_pkg::ctrl_cmd_t   cmd
);

  tksi_pkg::state_t state, state_next;
  logic out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tksi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    s_tready = 1'b0;
    unique case (state)
      tksi_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next = tksi_pkg::ST_COMPARE;
        end
      end
      tksi_pkg::ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next = tksi_pkg::ST_EXECUTE;
      end
      tksi_pkg::ST_EXECUTE: begin
        if (!out_valid || m_tready) begin
          cmd.execute = 1'b1;
          state_next = tksi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tksi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_tvalid = out_valid;

endmodule

>>> hw/rtl/tksi_datapath.sv
module tksi_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tksi_pkg::ctrl_cmd_t                 cmd,
  input  logic [tksi_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [1:0]                          s_tuser,
  output logic [tksi_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_we,
  input  logic [tksi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tksi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int N = tksi_pkg::MAX_ENTRIES;

  logic [tksi_pkg::ID_W-1:0]         entry_ids [N];
  logic signed [tksi_pkg::KEY_W-1:0] entry_keys [N];
  logic [tksi_pkg::CNT_W-1:0]        fill_count;
  logic [tksi_pkg::CAP_W-1:0]        capacity;
  logic                              ties_after;

  tksi_pkg::cmd_t                    cmd_r;
  logic [tksi_pkg::ID_W-1:0]         id_r;
  logic signed [tksi_pkg::KEY_W-1:0] key_r;
  logic [tksi_pkg::RIDX_W-1:0]       ridx_r;

  logic [N-1:0]                      gt, gt_next;
  logic [tksi_pkg::CNT_W-1:0]        pos;
  logic [tksi_pkg::PL_W-1:0]         pos_pl;
  logic [tksi_pkg::CW_W-1:0]         cap_ext, fill_ext, pos_ext;
  logic [tksi_pkg::CW_W-1:0]         held_ext;
  logic                              accept, full;
  logic [tksi_pkg::RD_W-1:0]         ridx_ext;
  logic                              rd_hit;
  logic                              do_insert;
  logic [tksi_pkg::CAP_W-1:0]        cap_new;

  logic                              accepted;
  logic [tksi_pkg::PLACED_W-1:0]     placed_at;
  logic [tksi_pkg::HELD_W-1:0]       entries_held;
  logic                              read_valid;
  logic [tksi_pkg::ID_W-1:0]         read_id;
  logic [tksi_pkg::KEY_W-1:0]        read_key;
  logic [tksi_pkg::CNT_W-1:0]        fill_next;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r <= tksi_pkg::cmd_t'(s_tuser);
      id_r <= s_tdata[31:0];
      key_r <= s_tdata[63:32];
      ridx_r <= s_tdata[67:64];
    end
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt_next[i] = (tksi_pkg::CNT_W'(i) < fill_count) &&
                   ((entry_keys[i] > key_r) || (ties_after && (entry_keys[i] == key_r)));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      gt <= gt_next;
    end
  end

  // The comparison vector is a thermometer code, so the insert point is one past its top.
  always_comb begin
    pos = '0;
    for (int i = 0; i < N; i++) begin
      if (gt[i]) pos = tksi_pkg::CNT_W'(i + 1);
    end
  end

  assign pos_pl = tksi_pkg::PL_W'(pos);
  assign cap_ext = tksi_pkg::CW_W'(capacity);
  assign fill_ext = tksi_pkg::CW_W'(fill_count);
  assign pos_ext = tksi_pkg::CW_W'(pos);
  assign accept = pos_ext < cap_ext;
  assign full = fill_ext >= cap_ext;
  assign do_insert = cmd.execute && (cmd_r == tksi_pkg::CMD_INSERT) && accept;

  assign ridx_ext = tksi_pkg::RD_W'(ridx_r);
  assign rd_hit = ridx_ext < tksi_pkg::RD_W'(fill_count);

  for (genvar g = 0; g < N; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_insert && !gt[g]) begin
        if (g == 0) begin
          entry_ids[g] <= id_r;
          entry_keys[g] <= key_r;
        end else if (gt[(g > 0) ? g - 1 : 0]) begin
          entry_ids[g] <= id_r;
          entry_keys[g] <= key_r;
        end else begin
          entry_ids[g] <= entry_ids[(g > 0) ? g - 1 : 0];
          entry_keys[g] <= entry_keys[(g > 0) ? g - 1 : 0];
        end
      end
    end
  end

  always_comb begin
    fill_next = fill_count;
    accepted = 1'b0;
    placed_at = '0;
    read_valid = 1'b0;
    read_id = '0;
    read_key = '0;
    case (cmd_r)
      tksi_pkg::CMD_INSERT: begin
        if (accept) begin
          accepted = 1'b1;
          placed_at = pos_pl[tksi_pkg::PLACED_W-1:0];
          if (!full) fill_next = fill_count + tksi_pkg::CNT_W'(1);
        end
      end
      tksi_pkg::CMD_READ: begin
        if (rd_hit) begin
          read_valid = 1'b1;
          read_id = entry_ids[ridx_ext[tksi_pkg::IDX_W-1:0]];
          read_key = entry_keys[ridx_ext[tksi_pkg::IDX_W-1:0]];
        end
      end
      tksi_pkg::CMD_CLEAR: begin
        fill_next = '0;
      end
      default: begin
      end
    endcase
    held_ext = tksi_pkg::CW_W'(fill_next);
    entries_held = held_ext[tksi_pkg::HELD_W-1:0];
  end

  assign cap_new = tksi_pkg::clamp_capacity(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      capacity <= tksi_pkg::clamp_capacity(tksi_pkg::CAP_W'(16));
      ties_after <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == tksi_pkg::REG_CAPACITY) begin
        capacity <= cap_new;
        if (fill_ext > tksi_pkg::CW_W'(cap_new)) fill_count <= tksi_pkg::CNT_W'(cap_new);
      end else if (cfg_index == tksi_pkg::REG_TIES_AFTER) begin
        ties_after <= cfg_data[0];
      end
    end else if (cmd.execute) begin
      fill_count <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      m_tdata <= {5'b0, read_key, read_id, read_valid, entries_held, placed_at, accepted};
    end
  end

endmodule

>>> hw/rtl/top_k_sorted_insert.sv
// A transaction is captured at acceptance, its key is compared against every entry in parallel
// on the next cycle with the result registered, and the shift-insert or read then lands in the
// output register once it is free or being taken. One transaction is in progress at a time, so
// the next is not accepted until the last has been executed; a result left waiting holds the
// next transaction in its last step. Synchronous reset empties the list, sets the capacity to
// full depth and ties_after to 0.
module top_k_sorted_insert (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // item_id[31:0], item_key[63:32], read_index[67:64], zero fill above.
  input  logic [tksi_pkg::IN_DATA_W-1:0]    s_tdata,
  // command[1:0].
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // accepted[0], placed_at[4:1], entries_held[9:5], read_valid[10],
  // read_id[42:11], read_key[74:43], zero fill above.
  output logic [tksi_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tksi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tksi_pkg::CFG_DATA_W-1:0]   cfg_data
);

  tksi_pkg::ctrl_cmd_t cmd;

  assign cfg_ready = 1'b1;

  tksi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  tksi_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
